// ===== design/u8dec_pkg.sv =====
// Shared types, constants and decode helpers for the UTF-8 character decoder.
package u8dec_pkg;

	localparam int WindowBytes = 4;

	typedef logic [7:0]  text_byte_t;
	typedef logic [2:0]  byte_cnt_t;
	typedef logic [20:0] code_point_t;

	localparam text_byte_t  CONT_MASK = 8'hC0;
	localparam text_byte_t  CONT_MARK = 8'h80;
	localparam code_point_t TAB_CHAR  = 21'h000009;
	localparam code_point_t TAB_REPL  = 21'h002007;
	localparam byte_cnt_t   CNT_MAX   = 3'd4;

	// Sequence length from the lead byte's leading ones; zero, one or over four means one byte.
	function automatic byte_cnt_t lead_len(input text_byte_t b);
		byte_cnt_t n;
		n = 3'd1;
		unique casez (b)
			8'b110?_????: n = 3'd2;
			8'b1110_????: n = 3'd3;
			8'b1111_0???: n = 3'd4;
			default:      n = 3'd1;
		endcase
		return n;
	endfunction

	function automatic byte_cnt_t is_cont(input text_byte_t b);
		return ((b & CONT_MASK) == CONT_MARK) ? 3'd1 : 3'd0;
	endfunction

endpackage

// ===== design/u8dec_in_if.sv =====
// Input channel: a four-byte text window and the count of bytes present.
interface u8dec_in_if;
	import u8dec_pkg::*;

	logic       valid;
	logic       ready;
	text_byte_t byte_a;
	text_byte_t byte_b;
	text_byte_t byte_c;
	text_byte_t byte_d;
	byte_cnt_t  bytes_present;

	modport source (output valid, byte_a, byte_b, byte_c, byte_d, bytes_present, input ready);
	modport sink   (input valid, byte_a, byte_b, byte_c, byte_d, bytes_present, output ready);
endinterface

// ===== design/u8dec_out_if.sv =====
// Output channel: one decoded character and the bytes it consumed.
interface u8dec_out_if;
	import u8dec_pkg::*;

	logic        valid;
	logic        ready;
	code_point_t code_point;
	byte_cnt_t   bytes_used;

	modport source (output valid, code_point, bytes_used, input ready);
	modport sink   (input valid, code_point, bytes_used, output ready);
endinterface

// ===== design/utf8_char_decoder_unit.sv =====
// Top level of the UTF-8 character decoder: three-stage pipeline, one character per cycle unless stalled.
//
// Decodes one character from a four-byte text window per transaction. A new
// transaction is taken every clock cycle unless backpressure stalls the
// pipeline. Each result passes through one register per stage (window
// masking, length selection, code point assembly) before it is on the output.
// Backpressure on the result channel stalls only the stages that hold data, so
// bubbles are squeezed out and nothing is dropped or repeated. Lead-byte
// leading ones pick a length of 1..4; the length drops to one byte (Latin-1)
// unless the lead plus the count of 10xxxxxx bytes among the other three
// reaches it - the continuation bytes need not be adjacent. Any result of 0x09
// is replaced by 0x2007. With no bytes present the result is zero with zero
// bytes used.
module utf8_char_decoder_unit (
	input  logic             clk,
	input  logic             arst_n,
	u8dec_in_if.sink         window,
	u8dec_out_if.source      result
);
	import u8dec_pkg::*;

	// Stage handshake: a stage may load when empty or when its successor moves.
	logic rdy_s1, rdy_s2, rdy_s3;

	// Stage 1: bytes past the count forced to zero
	logic       v_s1;
	logic       empty_s1;
	text_byte_t w_s1 [WindowBytes];

	// Stage 2: selected length
	logic       v_s2;
	logic       empty_s2;
	byte_cnt_t  len_s2;
	text_byte_t w_s2 [WindowBytes];

	// Stage 3: finished result
	logic        v_s3;
	code_point_t cp_s3;
	byte_cnt_t   used_s3;

	byte_cnt_t   avail;
	text_byte_t  w_in [WindowBytes];
	byte_cnt_t   len_sel, score;
	code_point_t cp_raw, cp_fix;

	assign rdy_s3       = !v_s3 || result.ready;
	assign rdy_s2       = !v_s2 || rdy_s3;
	assign rdy_s1       = !v_s1 || rdy_s2;
	assign window.ready = rdy_s1;

	// Stage 1 logic: clamp the count, zero absent bytes
	always_comb begin
		avail   = (window.bytes_present > CNT_MAX) ? CNT_MAX : window.bytes_present;
		w_in[0] = (avail > 3'd0) ? window.byte_a : '0;
		w_in[1] = (avail > 3'd1) ? window.byte_b : '0;
		w_in[2] = (avail > 3'd2) ? window.byte_c : '0;
		w_in[3] = (avail > 3'd3) ? window.byte_d : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= window.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && window.valid) begin
			empty_s1 <= (avail == 3'd0);
			for (int i = 0; i < WindowBytes; i++) begin
				w_s1[i] <= w_in[i];
			end
		end
	end

	// Stage 2 logic: length from the lead, fallback when too few continuations
	always_comb begin
		score   = 3'd1 + is_cont(w_s1[1]) + is_cont(w_s1[2]) + is_cont(w_s1[3]);
		len_sel = lead_len(w_s1[0]);
		if (len_sel > score) begin
			len_sel = 3'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			empty_s2 <= empty_s1;
			len_s2   <= len_sel;
			for (int i = 0; i < WindowBytes; i++) begin
				w_s2[i] <= w_s1[i];
			end
		end
	end

	// Stage 3 logic: gather payload bits, swap tab
	always_comb begin
		case (len_s2)
			3'd2: cp_raw = {10'd0, w_s2[0][4:0], w_s2[1][5:0]};
			3'd3: cp_raw = {5'd0, w_s2[0][3:0], w_s2[1][5:0], w_s2[2][5:0]};
			3'd4: cp_raw = {w_s2[0][2:0], w_s2[1][5:0], w_s2[2][5:0], w_s2[3][5:0]};
			default: cp_raw = {13'd0, w_s2[0]};
		endcase
		cp_fix = (cp_raw == TAB_CHAR) ? TAB_REPL : cp_raw;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			cp_s3   <= empty_s2 ? '0 : cp_fix;
			used_s3 <= empty_s2 ? '0 : len_s2;
		end
	end

	assign result.valid      = v_s3;
	assign result.code_point = cp_s3;
	assign result.bytes_used = used_s3;

	// A stalled stage-1 transaction stays put
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !rdy_s2) |=> (v_s1 && $stable(empty_s1) && $stable(w_s1[0])))
		else $error("stage 1 lost data under stall");

	// A stalled stage-2 transaction stays put
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !rdy_s3) |=> (v_s2 && $stable(len_s2) && $stable(empty_s2)))
		else $error("stage 2 lost data under stall");

	a_used_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.bytes_used <= CNT_MAX))
		else $error("bytes_used out of range");

	a_end_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.bytes_used == 3'd0) |-> (result.code_point == '0))
		else $error("end of text gave nonzero code point");

	a_no_tab: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.code_point != TAB_CHAR))
		else $error("tab not replaced");

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the UTF-8 character decoder: directed table, then random windows.
`timescale 1ns / 100ps

module testbench;
	import u8dec_pkg::*;

	// One text window as driven on the input channel.
	typedef struct packed {
		text_byte_t a;
		text_byte_t b;
		text_byte_t c;
		text_byte_t d;
		byte_cnt_t  present;
	} window_t;

	// One decoded character as seen on the result channel.
	typedef struct packed {
		code_point_t cp;
		byte_cnt_t   used;
	} char_t;

	// Directed row: window plus an optional hand-typed expectation.
	// typed = 0 means the row is checked against decode_char instead.
	typedef struct packed {
		text_byte_t  a;
		text_byte_t  b;
		text_byte_t  c;
		text_byte_t  d;
		byte_cnt_t   present;
		logic        typed;
		code_point_t cp;
		byte_cnt_t   used;
	} stim_row_t;

	localparam int NUM_DIRECTED   = 23;
	localparam int ITEMS_PER_PASS = 400;
	localparam int PIPE_LATENCY   = 3;
	// Keep a wide margin over the slowest run.
	localparam int CYCLE_LIMIT    = 200000;

	// Idle percentages per pass: sender, receiver.
	localparam int SEND_IDLE [3] = '{33, 75, 0};
	localparam int RECV_IDLE [3] = '{75, 33, 0};

	localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
		// end of text: bytes present zero, garbage in the window is ignored
		'{8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd0, 1'b1, 21'h000000, 3'd0},
		// plain ASCII, smallest nonzero count
		'{8'h41, 8'h00, 8'h00, 8'h00, 3'd1, 1'b1, 21'h000041, 3'd1},
		// NUL byte is still one byte consumed
		'{8'h00, 8'h00, 8'h00, 8'h00, 3'd4, 1'b1, 21'h000000, 3'd1},
		// all-ones lead (eight leading ones) falls back to Latin-1
		'{8'hFF, 8'hBF, 8'hBF, 8'hBF, 3'd4, 1'b1, 21'h0000FF, 3'd1},
		// tab replacement
		'{8'h09, 8'h00, 8'h00, 8'h00, 3'd1, 1'b1, 21'h002007, 3'd1},
		// overlong two-byte tab
		'{8'hC0, 8'h89, 8'h00, 8'h00, 3'd2, 1'b1, 21'h002007, 3'd2},
		// largest four-byte code point
		'{8'hF7, 8'hBF, 8'hBF, 8'hBF, 3'd4, 1'b1, 21'h1FFFFF, 3'd4},
		// overlong four-byte tab
		'{8'hF0, 8'h80, 8'h80, 8'h89, 3'd4, 1'b1, 21'h002007, 3'd4},
		// top ASCII value with continuations behind it
		'{8'h7F, 8'h80, 8'h80, 8'h80, 3'd4, 1'b1, 21'h00007F, 3'd1},
		// well-formed two, three and four byte sequences
		'{8'hC3, 8'hA9, 8'h00, 8'h00, 3'd2, 1'b0, 21'h000000, 3'd0},
		'{8'hE2, 8'h82, 8'hAC, 8'h00, 3'd3, 1'b0, 21'h000000, 3'd0},
		'{8'hF0, 8'h9F, 8'h98, 8'h80, 3'd4, 1'b0, 21'h000000, 3'd0},
		// scattered continuation: two-byte lead, ASCII, then continuation
		'{8'hC3, 8'h41, 8'hA9, 8'h00, 3'd3, 1'b0, 21'h000000, 3'd0},
		// scattered continuation on a three-byte lead
		'{8'hE2, 8'h82, 8'h41, 8'hAC, 3'd4, 1'b0, 21'h000000, 3'd0},
		// lead without any continuation
		'{8'hC3, 8'h41, 8'h00, 8'h00, 3'd2, 1'b0, 21'h000000, 3'd0},
		// sequence cut short by the byte count
		'{8'hE2, 8'h82, 8'hAC, 8'h00, 3'd2, 1'b0, 21'h000000, 3'd0},
		'{8'hE2, 8'h82, 8'hAC, 8'h41, 3'd1, 1'b0, 21'h000000, 3'd0},
		// counts above four read as four
		'{8'hF0, 8'h9F, 8'h98, 8'h80, 3'd5, 1'b0, 21'h000000, 3'd0},
		'{8'hF0, 8'h9F, 8'h98, 8'h80, 3'd6, 1'b0, 21'h000000, 3'd0},
		'{8'hF0, 8'h9F, 8'h98, 8'h80, 3'd7, 1'b0, 21'h000000, 3'd0},
		// lone continuation as lead
		'{8'h80, 8'hBF, 8'hBF, 8'hBF, 3'd4, 1'b0, 21'h000000, 3'd0},
		// five leading ones
		'{8'hF8, 8'hBF, 8'hBF, 8'hBF, 3'd4, 1'b0, 21'h000000, 3'd0},
		// seven leading ones, fourth byte masked off
		'{8'hFE, 8'h80, 8'h80, 8'h80, 3'd3, 1'b0, 21'h000000, 3'd0}
	};

	logic clk;
	logic arst_n;

	u8dec_in_if  window_if ();
	u8dec_out_if result_if ();

	utf8_char_decoder_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.window (window_if),
		.result (result_if)
	);

	// Characters accepted on the input side, oldest first, awaiting their result.
	char_t pending_chars [$];
	int    mismatch_count = 0;
	int    send_idle_pct  = 0;
	int    recv_idle_pct  = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Independent decode of one window, used as the golden value.
	function automatic char_t decode_char(input window_t w);
		text_byte_t  wb [4];
		int          avail;
		int          ones;
		int          seq_len;
		int          score;
		int          bit_idx;
		code_point_t cp;
		char_t       r;
		avail = (w.present > 3'd4) ? 4 : int'(w.present);
		wb[0] = (avail > 0) ? w.a : 8'h00;
		wb[1] = (avail > 1) ? w.b : 8'h00;
		wb[2] = (avail > 2) ? w.c : 8'h00;
		wb[3] = (avail > 3) ? w.d : 8'h00;
		if (avail == 0) begin
			r.cp   = '0;
			r.used = '0;
			return r;
		end
		ones    = 0;
		bit_idx = 7;
		while (bit_idx >= 0 && wb[0][bit_idx]) begin
			ones++;
			bit_idx--;
		end
		seq_len = (ones == 0 || ones > 4) ? 1 : ones;
		// lead counts as one; continuations may sit anywhere in the other three
		score = 1;
		for (int i = 1; i < 4; i++) begin
			if (wb[i][7:6] == 2'b10) score++;
		end
		if (seq_len > score) seq_len = 1;
		case (seq_len)
			2: begin
				cp = code_point_t'({wb[0][4:0], wb[1][5:0]});
			end
			3: begin
				cp = code_point_t'({wb[0][3:0], wb[1][5:0], wb[2][5:0]});
			end
			4: begin
				cp = code_point_t'({wb[0][2:0], wb[1][5:0], wb[2][5:0], wb[3][5:0]});
			end
			default: begin
				cp = code_point_t'(wb[0]);
			end
		endcase
		if (cp == TAB_CHAR) cp = TAB_REPL;
		r.cp   = cp;
		r.used = byte_cnt_t'(seq_len);
		return r;
	endfunction

	// Random window: mostly well-formed UTF-8, some scattered continuations, some noise.
	function automatic window_t next_window();
		window_t    w;
		text_byte_t wb [4];
		int         kind;
		int         seq_len;
		int         present;
		for (int i = 0; i < 4; i++) wb[i] = text_byte_t'($urandom);
		kind    = $urandom_range(0, 9);
		seq_len = $urandom_range(1, 4);
		present = $urandom_range(0, 7);
		if (kind <= 5) begin
			case (seq_len)
				1: wb[0] = {1'b0, wb[0][6:0]};
				2: wb[0] = {3'b110, wb[0][4:0]};
				3: wb[0] = {4'b1110, wb[0][3:0]};
				default: wb[0] = {5'b11110, wb[0][2:0]};
			endcase
			for (int i = 1; i < seq_len; i++) wb[i] = {2'b10, wb[i][5:0]};
			// occasional tab, plain or overlong
			if ($urandom_range(0, 15) == 0) begin
				if (seq_len == 1) wb[0] = 8'h09;
				else if (seq_len == 2) begin
					wb[0] = 8'hC0;
					wb[1] = 8'h89;
				end
			end
			if ($urandom_range(0, 3) != 0) present = $urandom_range(seq_len, 4);
		end else if (kind <= 7) begin
			// multi-byte lead with continuations dropped in at random slots
			case ($urandom_range(2, 4))
				2: wb[0] = {3'b110, wb[0][4:0]};
				3: wb[0] = {4'b1110, wb[0][3:0]};
				default: wb[0] = {5'b11110, wb[0][2:0]};
			endcase
			for (int i = 1; i < 4; i++) begin
				if ($urandom_range(0, 1) == 1) wb[i] = {2'b10, wb[i][5:0]};
			end
			present = $urandom_range(1, 7);
		end
		w.a       = wb[0];
		w.b       = wb[1];
		w.c       = wb[2];
		w.d       = wb[3];
		w.present = byte_cnt_t'(present);
		return w;
	endfunction

	// Drive one window; record its expected character when the transaction completes.
	// valid is left high afterwards so back-to-back transactions never toggle it.
	task automatic send_window(input window_t w, input char_t exp_char);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			window_if.valid <= 1'b0;
			@(negedge clk);
		end
		window_if.valid         <= 1'b1;
		window_if.byte_a        <= w.a;
		window_if.byte_b        <= w.b;
		window_if.byte_c        <= w.c;
		window_if.byte_d        <= w.d;
		window_if.bytes_present <= w.present;
		@(posedge clk);
		while (!window_if.ready) @(posedge clk);
		pending_chars.insert(pending_chars.size(), exp_char);
	endtask

	// Stop sending and hold off until every pending character has come back.
	task automatic drain_pending();
		@(negedge clk);
		window_if.valid <= 1'b0;
		while (pending_chars.size() != 0) @(posedge clk);
	endtask

	// Receiver backpressure, re-rolled every cycle.
	always @(negedge clk) begin
		result_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// Result checker: every completed output transaction pops the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && result_if.valid && result_if.ready) begin
			if (pending_chars.size() == 0) begin
				$error("unexpected result: code_point %h, bytes_used %0d",
					result_if.code_point, result_if.bytes_used);
				mismatch_count++;
			end else begin
				if (result_if.code_point !== pending_chars[0].cp) begin
					$error("code_point: expected %h, got %h",
						pending_chars[0].cp, result_if.code_point);
					mismatch_count++;
				end
				if (result_if.bytes_used !== pending_chars[0].used) begin
					$error("bytes_used: expected %0d, got %0d",
						pending_chars[0].used, result_if.bytes_used);
					mismatch_count++;
				end
				void'(pending_chars.pop_front());
			end
		end
	end

	// Watchdog.
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		window_t win;
		char_t   exp_char;
		arst_n                  = 1'b0;
		window_if.valid         = 1'b0;
		window_if.byte_a        = '0;
		window_if.byte_b        = '0;
		window_if.byte_c        = '0;
		window_if.byte_d        = '0;
		window_if.bytes_present = '0;
		send_idle_pct           = SEND_IDLE[0];
		recv_idle_pct           = RECV_IDLE[0];
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed table, under the first idle profile.
		for (int r = 0; r < NUM_DIRECTED; r++) begin
			win.a       = DIRECTED[r].a;
			win.b       = DIRECTED[r].b;
			win.c       = DIRECTED[r].c;
			win.d       = DIRECTED[r].d;
			win.present = DIRECTED[r].present;
			if (DIRECTED[r].typed) begin
				exp_char.cp   = DIRECTED[r].cp;
				exp_char.used = DIRECTED[r].used;
			end else begin
				exp_char = decode_char(win);
			end
			send_window(win, exp_char);
		end
		drain_pending();

		// Random passes: sender-light/receiver-heavy idling, then swapped, then none.
		// Each pass ends with a full drain, so the sender sits idle with nothing in flight.
		for (int p = 0; p < 3; p++) begin
			send_idle_pct = SEND_IDLE[p];
			recv_idle_pct = RECV_IDLE[p];
			for (int n = 0; n < ITEMS_PER_PASS; n++) begin
				win = next_window();
				send_window(win, decode_char(win));
			end
			drain_pending();
		end

		// Let the pipeline run out so stray results get caught.
		repeat (PIPE_LATENCY * 4) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
